@@ rtl/core/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types, constants and the divider step for the RGB to hue pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int HUE_W    = 13;
    localparam int QUOT_W   = 14;
    localparam int DEN_W    = CHAN_W + 1;
    localparam int NUM_W    = QUOT_W + CHAN_W;
    localparam int ACC_W    = 24;

    localparam int HUE_SECTOR  = 960;
    localparam int HUE_FULL    = 6 * HUE_SECTOR;
    localparam int GREY_SPREAD = 2;

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = QUOT_W / DIV_STEPS_PER_STAGE;

    typedef logic [1:0] t_sect;
    localparam t_sect SECT_RED   = 2'd0;
    localparam t_sect SECT_GREEN = 2'd1;
    localparam t_sect SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic              grey;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] work;
    } t_div_data;

    // One restoring division step. Dividend bits leave the top of work while
    // quotient bits enter at the bottom.
    function automatic t_div_data div_step(input t_div_data d);
        t_div_data        res;
        logic [DEN_W:0]   trial;
        logic             take;
        res   = d;
        trial = {d.rem, d.work[QUOT_W-1]};
        take  = (trial >= {1'b0, d.den});
        if (take) begin
            trial = trial - {1'b0, d.den};
        end
        res.rem  = trial[DEN_W-1:0];
        res.work = {d.work[QUOT_W-2:0], take};
        return res;
    endfunction

endpackage

@@ rtl/core/rgb_to_hue_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hue_unit
// HSV hue of a packed RGB pixel, in sixteenths of a degree, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel | Valid       | Ready       | Payload
//  --------+-------------+-------------+---------------------
//  Input   | i_in_valid  | o_in_ready  | i_rgb_word
//  Output  | o_out_valid | i_out_ready | o_hue, o_is_grey
//
//  One pixel is accepted per cycle while the output is not stalled. Ten register
//  stages (two front stages, seven divider stages of two quotient bits each,
//  and the output stage) carry each pixel from its input to the output register.
//  Reset clears all valid bits; the data registers are not reset.
//  The whole pipeline advances together whenever the output register is empty
//  or its result is being transferred, so a stall holds every stage in place.
// ----------------------------------------------------------------------------
module rgb_to_hue_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rth_pkg::PIX_W-1:0] i_rgb_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rth_pkg::HUE_W-1:0] o_hue,
    output logic                      o_is_grey
);

    logic                en;
    logic                stg_valid [rth_pkg::DIV_STAGES+1];
    rth_pkg::t_div_data  stg_data  [rth_pkg::DIV_STAGES+1];

    logic [rth_pkg::QUOT_W-1:0] quot;
    logic [rth_pkg::HUE_W-1:0]  n_hue;

    logic                       r_out_valid;
    logic [rth_pkg::HUE_W-1:0]  r_hue;
    logic                       r_is_grey;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    rth_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_rgb_word (i_rgb_word),
        .o_valid    (stg_valid[0]),
        .o_data     (stg_data[0])
    );

    for (genvar k = 0; k < rth_pkg::DIV_STAGES; k++) begin : g_div
        rth_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    assign quot = stg_data[rth_pkg::DIV_STAGES].work;

    always_comb begin
        if (stg_data[rth_pkg::DIV_STAGES].grey) begin
            n_hue = '0;
        end else if (quot >= rth_pkg::QUOT_W'(rth_pkg::HUE_FULL)) begin
            n_hue = rth_pkg::HUE_W'(quot - rth_pkg::QUOT_W'(rth_pkg::HUE_FULL));
        end else begin
            n_hue = quot[rth_pkg::HUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= stg_valid[rth_pkg::DIV_STAGES];
        end
        if (en) begin
            r_hue     <= n_hue;
            r_is_grey <= stg_data[rth_pkg::DIV_STAGES].grey;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hue       = r_hue;
    assign o_is_grey   = r_is_grey;

endmodule

@@ rtl/core/rth_prep.sv @@
// ----------------------------------------------------------------------------
// rth_prep
// Two front stages: channel extremes and spread, then the scaled numerator
// and the divider operands.
// ----------------------------------------------------------------------------
module rth_prep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [rth_pkg::PIX_W-1:0] i_rgb_word,
    output logic                      o_valid,
    output rth_pkg::t_div_data        o_data
);

    logic [rth_pkg::CHAN_W-1:0] red, green, blue;
    logic [rth_pkg::CHAN_W-1:0] mx, mn;
    rth_pkg::t_sect             sect;
    logic signed [rth_pkg::CHAN_W:0] diff;

    logic                            r_s1_valid;
    logic                            r_s1_grey;
    logic [rth_pkg::CHAN_W-1:0]      r_s1_delta;
    rth_pkg::t_sect                  r_s1_sect;
    logic signed [rth_pkg::CHAN_W:0] r_s1_diff;

    logic signed [rth_pkg::ACC_W-1:0] delta_s;
    logic signed [rth_pkg::ACC_W-1:0] offset;
    logic signed [rth_pkg::ACC_W-1:0] num;
    logic [rth_pkg::NUM_W-1:0]        dividend;

    logic               r_s2_valid;
    rth_pkg::t_div_data r_s2_data;
    rth_pkg::t_div_data n_s2_data;

    function automatic logic signed [rth_pkg::ACC_W-1:0] ACC_W_C(input int v);
        return rth_pkg::ACC_W'(v);
    endfunction

    assign red   = i_rgb_word[3*rth_pkg::CHAN_W-1:2*rth_pkg::CHAN_W];
    assign green = i_rgb_word[2*rth_pkg::CHAN_W-1:rth_pkg::CHAN_W];
    assign blue  = i_rgb_word[rth_pkg::CHAN_W-1:0];

    always_comb begin
        priority if (red >= green && red >= blue) begin
            sect = rth_pkg::SECT_RED;
            mx   = red;
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= blue) begin
            sect = rth_pkg::SECT_GREEN;
            mx   = green;
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sect = rth_pkg::SECT_BLUE;
            mx   = blue;
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        mn = red;
        if (green < mn) begin
            mn = green;
        end
        if (blue < mn) begin
            mn = blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_s1_delta <= mx - mn;
            r_s1_grey  <= ((mx - mn) <= rth_pkg::CHAN_W'(rth_pkg::GREY_SPREAD));
            r_s1_sect  <= sect;
            r_s1_diff  <= diff;
        end
    end

    assign delta_s = $signed({{(rth_pkg::ACC_W-rth_pkg::CHAN_W){1'b0}}, r_s1_delta});

    always_comb begin
        unique case (r_s1_sect)
            rth_pkg::SECT_GREEN: offset = delta_s * ACC_W_C(2 * rth_pkg::HUE_SECTOR);
            rth_pkg::SECT_BLUE:  offset = delta_s * ACC_W_C(4 * rth_pkg::HUE_SECTOR);
            default:             offset = '0;
        endcase
        num = rth_pkg::ACC_W'(r_s1_diff) * ACC_W_C(rth_pkg::HUE_SECTOR) + offset;
        if (num < 0) begin
            num = num + delta_s * ACC_W_C(rth_pkg::HUE_FULL);
        end
        dividend = rth_pkg::NUM_W'({num[rth_pkg::NUM_W-2:0], 1'b0})
                 + rth_pkg::NUM_W'(r_s1_delta);
        n_s2_data.grey = r_s1_grey;
        n_s2_data.den  = {r_s1_delta, 1'b0};
        n_s2_data.rem  = rth_pkg::DEN_W'(dividend[rth_pkg::NUM_W-1:rth_pkg::QUOT_W]);
        n_s2_data.work = dividend[rth_pkg::QUOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (i_en) begin
            r_s2_data <= n_s2_data;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

endmodule

@@ rtl/core/rth_div_stage.sv @@
// ----------------------------------------------------------------------------
// rth_div_stage
// One register stage of the pipelined restoring divider.
// ----------------------------------------------------------------------------
module rth_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rth_pkg::t_div_data i_data,
    output logic               o_valid,
    output rth_pkg::t_div_data o_data
);

    logic               r_valid;
    rth_pkg::t_div_data r_data;
    rth_pkg::t_div_data n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < rth_pkg::DIV_STEPS_PER_STAGE; s++) begin
            n_data = rth_pkg::div_step(n_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sim/tb_rgb_to_hue_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_to_hue_unit
// Self-checking testbench for the RGB to hue pipeline. Each accepted pixel is
// converted to its expected hue and grey flag by an integer predictor. The
// expectations queue up and are compared in order with every result
// transfer. Directed pixels cover extremes, ties, grey spreads and rounding.
// Random pixels then run under several sender and receiver idling mixes, a
// long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_rgb_to_hue_unit;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 260;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [rth_pkg::HUE_W-1:0] hue;
        logic                      grey;
    } t_hue_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [rth_pkg::PIX_W-1:0]  i_rgb_word;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [rth_pkg::HUE_W-1:0]  o_hue;
    logic                       o_is_grey;

    t_hue_result pending_hues[$];
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    int          rx_hold_left  = 0;

    rgb_to_hue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rgb_word  (i_rgb_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hue       (o_hue),
        .o_is_grey   (o_is_grey)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_hue_result predict_hue(input logic [rth_pkg::PIX_W-1:0] pixel);
        t_hue_result res;
        int red, green, blue, hi, lo, spread, num, quot;
        red    = pixel[23:16];
        green  = pixel[15:8];
        blue   = pixel[7:0];
        hi     = red;
        lo     = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        spread = hi - lo;
        res.hue  = '0;
        res.grey = 1'b1;
        if (spread > rth_pkg::GREY_SPREAD) begin
            if (hi == red) begin
                num = rth_pkg::HUE_SECTOR * (green - blue);
            end else if (hi == green) begin
                num = rth_pkg::HUE_SECTOR * (blue - red) + 2 * rth_pkg::HUE_SECTOR * spread;
            end else begin
                num = rth_pkg::HUE_SECTOR * (red - green) + 4 * rth_pkg::HUE_SECTOR * spread;
            end
            if (num < 0) num += rth_pkg::HUE_FULL * spread;
            quot = (2 * num + spread) / (2 * spread);
            if (quot >= rth_pkg::HUE_FULL) quot -= rth_pkg::HUE_FULL;
            res.hue  = quot[rth_pkg::HUE_W-1:0];
            res.grey = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [7:0] edge_channel();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            3: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [rth_pkg::PIX_W-1:0] random_pixel();
        logic [7:0] ch_a, ch_b, ch_c;
        int base;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                return rth_pkg::PIX_W'($urandom_range(24'hFFFFFF));
            end
            5, 6: begin
                base = $urandom_range(255);
                ch_a = 8'((base + $urandom_range(3) > 255) ? 255 : base + $urandom_range(3));
                ch_b = 8'((base + $urandom_range(3) > 255) ? 255 : base + $urandom_range(3));
                ch_c = 8'((base + $urandom_range(3) > 255) ? 255 : base + $urandom_range(3));
                return {ch_a, ch_b, ch_c};
            end
            7, 8: begin
                ch_a = 8'($urandom_range(255));
                ch_b = 8'($urandom_range(255));
                case ($urandom_range(2))
                    0: return {ch_a, ch_a, ch_b};
                    1: return {ch_a, ch_b, ch_a};
                    default: return {ch_b, ch_a, ch_a};
                endcase
            end
            default: begin
                return {edge_channel(), edge_channel(), edge_channel()};
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [rth_pkg::PIX_W-1:0] pixel);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rgb_word <= pixel;
        do @(posedge i_clk); while (!o_in_ready);
        pending_hues.push_back(predict_hue(pixel));
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (pending_hues.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_burst(input int count);
        for (int n = 0; n < count; n++) begin
            while ($urandom_range(99) < tx_idle_pct) idle_cycle();
            send_pixel(random_pixel());
        end
    endtask

    // Receiver: random stalls, or a forced hold-off while rx_hold_left runs.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_hue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_hues.size() == 0) begin
                $error("unexpected result transfer: hue %0d, is_grey %0b", o_hue, o_is_grey);
                error_count++;
            end else begin
                want = pending_hues.pop_front();
                if (o_hue !== want.hue) begin
                    $error("hue mismatch: expected %0d, actual %0d", want.hue, o_hue);
                    error_count++;
                end
                if (o_is_grey !== want.grey) begin
                    $error("is_grey mismatch: expected %0b, actual %0b", want.grey, o_is_grey);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [rth_pkg::PIX_W-1:0] pixels[$];
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pixels = {24'h000000, 24'hFFFFFF, 24'h020000, 24'h000200, 24'h000003,
                  24'h030000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                  24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE, 24'h800100,
                  24'h800001, 24'h01FF02, 24'hFE01FF, 24'h7F8081, 24'h5A5A5D,
                  24'hAAAAAA, 24'h123456};
        foreach (pixels[k]) send_pixel(pixels[k]);
        idle_cycle();
        wait_for_drain();
    endtask

    task automatic test_random_phases();
        int tx_mix[4] = '{0, 47, 0, 31};
        int rx_mix[4] = '{0, 0, 47, 31};
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_mix[p];
            rx_stall_pct = rx_mix[p];
            send_random_burst(PHASE_ITEMS);
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    task automatic test_output_hold_off();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_pixel(random_pixel());
        rx_hold_left = 60;
        send_random_burst(40);
    endtask

    task automatic test_drain_pause();
        tx_idle_pct  = 10;
        rx_stall_pct = 20;
        send_random_burst(20);
        idle_cycle();
        wait_for_drain();
        send_random_burst(20);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rgb_word  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_output_hold_off();
        test_drain_pause();

        idle_cycle();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_hues.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rth_pkg.sv
rtl/core/rth_prep.sv
rtl/core/rth_div_stage.sv
rtl/core/rgb_to_hue_unit.sv
sim/tb_rgb_to_hue_unit.sv
